// ===== rtl/i2cmrt_pkg.sv =====
// Shared types, phase codes and word layouts for the I2C register transfer master.
// No dependencies; used by i2cmrt_step and i2c_master_register_transfer.
package i2cmrt_pkg;

    // Bus sequence phases
    localparam int PhaseW = 5;
    typedef logic [PhaseW-1:0] phase_t;

    localparam phase_t PH_IDLE = 5'd0;
    localparam phase_t PH_ST0  = 5'd1;
    localparam phase_t PH_ST1  = 5'd2;
    localparam phase_t PH_ST2  = 5'd3;
    localparam phase_t PH_TXL  = 5'd4;
    localparam phase_t PH_TXD  = 5'd5;
    localparam phase_t PH_TXH  = 5'd6;
    localparam phase_t PH_AKR  = 5'd7;
    localparam phase_t PH_AKH  = 5'd8;
    localparam phase_t PH_AKE  = 5'd9;
    localparam phase_t PH_RXR  = 5'd10;
    localparam phase_t PH_RXL  = 5'd11;
    localparam phase_t PH_RXH  = 5'd12;
    localparam phase_t PH_MKS  = 5'd13;
    localparam phase_t PH_MKH  = 5'd14;
    localparam phase_t PH_MKL  = 5'd15;
    localparam phase_t PH_SPL  = 5'd16;
    localparam phase_t PH_SPH  = 5'd17;
    localparam phase_t PH_SPE  = 5'd18;

    // Request modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Address byte construction
    localparam logic [7:0] ADDR_PREFIX = 8'hE8;
    localparam logic [7:0] DIR_READ    = 8'h01;
    localparam logic [7:0] DIR_WRITE   = 8'h00;

    // Byte slots of a transfer
    localparam logic [2:0] BYTE_ADDR   = 3'd0;
    localparam logic [2:0] BYTE_REG    = 3'd1;
    localparam logic [2:0] BYTE_DATA_L = 3'd2;
    localparam logic [2:0] BYTE_RD_LO  = 3'd3;
    localparam logic [2:0] BYTE_LAST   = 3'd4;
    localparam logic [3:0] BITS_BYTE   = 4'd8;

    // Word widths on the streams
    localparam int InDataW  = 32;
    localparam int InUserW  = 2;
    localparam int OutDataW = 24;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  dev_addr;
        logic [7:0]  reg_index;
        logic [15:0] write_data;
        logic        sda_sample;
    } tick_t;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  bit_count;
        logic [7:0]  shift_byte;
        logic [2:0]  byte_index;
        logic        is_read;
        logic [2:0]  held_addr;
        logic [7:0]  held_reg;
        logic [15:0] held_data;
        logic [15:0] read_accum;
        logic        scl;
        logic        sda;
    } ctrl_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        ok;
        logic        done_res;
        logic        busy_res;
        logic        sda_level;
        logic        scl_level;
    } result_t;

    // Byte to shift out for a given slot
    function automatic logic [7:0] byte_to_send(input ctrl_t st, input logic [2:0] idx);
        logic [7:0] b;
        if (idx == BYTE_ADDR) begin
            b = ADDR_PREFIX | {5'd0, st.held_addr} | DIR_WRITE;
        end else if (idx == BYTE_REG) begin
            b = st.held_reg;
        end else if (st.is_read) begin
            b = ADDR_PREFIX | {5'd0, st.held_addr} | DIR_READ;
        end else if (idx == BYTE_DATA_L) begin
            b = st.held_data[7:0];
        end else begin
            b = st.held_data[15:8];
        end
        return b;
    endfunction

endpackage

// ===== rtl/i2cmrt_step.sv =====
// One pin-update step of the I2C register transfer sequence.
// Combinational; depends on i2cmrt_pkg for the phase codes and structs.
module i2cmrt_step
    import i2cmrt_pkg::*;
(
    input  ctrl_t   cur,
    input  tick_t   tick,
    output ctrl_t   nxt,
    output result_t res
);

    logic       done;
    logic       okv;
    logic [2:0] idx_inc;
    logic [7:0] shift_rx;

    assign idx_inc  = cur.byte_index + 3'd1;
    assign shift_rx = (cur.bit_count != 4'd0) ? {cur.shift_byte[6:0], tick.sda_sample}
                                              : cur.shift_byte;

    // Advance the bus sequence by one step
    always_comb begin
        nxt  = cur;
        done = 1'b0;
        okv  = 1'b0;
        unique case (cur.phase)
            PH_IDLE: begin
                if (tick.mode == MODE_WRITE || tick.mode == MODE_READ) begin
                    nxt.is_read    = (tick.mode == MODE_READ);
                    nxt.held_addr  = tick.dev_addr;
                    nxt.held_reg   = tick.reg_index;
                    nxt.held_data  = tick.write_data;
                    nxt.read_accum = 16'd0;
                    nxt.byte_index = 3'd0;
                    nxt.bit_count  = 4'd0;
                    nxt.shift_byte = 8'd0;
                    nxt.sda        = 1'b1;
                    nxt.scl        = 1'b1;
                    nxt.phase      = PH_ST1;
                end
            end
            PH_ST0: begin
                nxt.sda   = 1'b1;
                nxt.scl   = 1'b1;
                nxt.phase = PH_ST1;
            end
            PH_ST1: begin
                nxt.sda   = 1'b0;
                nxt.phase = PH_ST2;
            end
            PH_ST2: begin
                // Abort when the bus did not follow our START
                if (tick.sda_sample) begin
                    done      = 1'b1;
                    nxt.phase = PH_IDLE;
                end else begin
                    nxt.sda        = 1'b0;
                    nxt.shift_byte = byte_to_send(cur, cur.byte_index);
                    nxt.bit_count  = 4'd0;
                    nxt.phase      = PH_TXL;
                end
            end
            PH_TXL: begin
                nxt.scl   = 1'b0;
                nxt.phase = (cur.bit_count >= BITS_BYTE) ? PH_AKR : PH_TXD;
            end
            PH_TXD: begin
                nxt.sda        = cur.shift_byte[7];
                nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
                nxt.phase      = PH_TXH;
            end
            PH_TXH: begin
                nxt.scl       = 1'b1;
                nxt.bit_count = cur.bit_count + 4'd1;
                nxt.phase     = PH_TXL;
            end
            PH_AKR: begin
                nxt.sda   = 1'b1;
                nxt.phase = PH_AKH;
            end
            PH_AKH: begin
                nxt.scl   = 1'b1;
                nxt.phase = PH_AKE;
            end
            PH_AKE: begin
                nxt.scl        = 1'b0;
                nxt.byte_index = idx_inc;
                if (cur.is_read && idx_inc == BYTE_DATA_L) begin
                    nxt.phase = PH_ST0;
                end else if (cur.is_read && idx_inc >= BYTE_RD_LO) begin
                    nxt.phase = PH_RXR;
                end else if (!cur.is_read && idx_inc >= BYTE_LAST) begin
                    nxt.phase = PH_SPL;
                end else begin
                    nxt.shift_byte = byte_to_send(cur, idx_inc);
                    nxt.bit_count  = 4'd0;
                    nxt.phase      = PH_TXD;
                end
            end
            PH_RXR: begin
                nxt.sda        = 1'b1;
                nxt.bit_count  = 4'd0;
                nxt.shift_byte = 8'd0;
                nxt.phase      = PH_RXL;
            end
            PH_RXL: begin
                // Shift in the bit sampled during the previous SCL high
                nxt.scl        = 1'b0;
                nxt.shift_byte = shift_rx;
                if (cur.bit_count >= BITS_BYTE) begin
                    if (cur.byte_index == BYTE_RD_LO) begin
                        nxt.read_accum = {cur.read_accum[15:8], shift_rx};
                    end else begin
                        nxt.read_accum = {shift_rx, cur.read_accum[7:0]};
                    end
                    nxt.phase = PH_MKS;
                end else begin
                    nxt.phase = PH_RXH;
                end
            end
            PH_RXH: begin
                nxt.scl       = 1'b1;
                nxt.bit_count = cur.bit_count + 4'd1;
                nxt.phase     = PH_RXL;
            end
            PH_MKS: begin
                // ACK the low byte, NACK the high byte
                nxt.sda   = (cur.byte_index != BYTE_RD_LO);
                nxt.phase = PH_MKH;
            end
            PH_MKH: begin
                nxt.scl   = 1'b1;
                nxt.phase = PH_MKL;
            end
            PH_MKL: begin
                nxt.scl        = 1'b0;
                nxt.byte_index = idx_inc;
                nxt.phase      = (idx_inc == BYTE_LAST) ? PH_RXR : PH_SPL;
            end
            PH_SPL: begin
                nxt.sda   = 1'b0;
                nxt.phase = PH_SPH;
            end
            PH_SPH: begin
                nxt.scl   = 1'b1;
                nxt.phase = PH_SPE;
            end
            PH_SPE: begin
                nxt.sda   = 1'b1;
                done      = 1'b1;
                okv       = 1'b1;
                nxt.phase = PH_IDLE;
            end
            default: begin
                nxt.phase = PH_IDLE;
            end
        endcase
    end

    // Report the pins and status after this step
    always_comb begin
        res.scl_level = nxt.scl;
        res.sda_level = nxt.sda;
        res.busy_res  = (nxt.phase != PH_IDLE);
        res.done_res  = done;
        res.ok        = okv;
        res.read_data = nxt.read_accum;
    end

endmodule

// ===== rtl/i2c_master_register_transfer.sv =====
// Top level of the bit-level I2C master for 16-bit register accesses.
// Depends on i2cmrt_pkg and i2cmrt_step.

// Each input word is one pin-update tick and yields exactly one result word
// with the SCL/SDA drive levels and the transfer status after that tick. The
// block takes one tick per clock cycle unless the result side stalls: the tick
// goes into an input register, one step of the bus sequencer runs between that
// register and the output register, which holds the result until it is taken.
// The sequencer state is updated once per step, so a stall on the result side
// only holds the pipeline. A write transfer runs through START, four bytes
// with ack slots and STOP; a read sends three bytes with a repeated START
// before the third, then receives two bytes and ends with STOP.
// Requests are only taken while the sequencer is idle. A failed START check
// ends the transfer with done set and ok clear.
module i2c_master_register_transfer
    import i2cmrt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // dev_addr[2:0], reg_index[10:3], write_data[26:11], sda_sample[27], zero pad
    input  logic [InDataW-1:0]   s_tdata,
    // mode[1:0]
    input  logic [InUserW-1:0]   s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // scl_level[0], sda_level[1], busy_res[2], done_res[3], ok[4],
    // read_data[20:5], zero pad
    output logic [OutDataW-1:0]  m_tdata
);

    logic    in_valid_reg;
    tick_t   in_tick_reg;
    ctrl_t   ctrl_reg;
    ctrl_t   ctrl_next;
    result_t step_res;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    advance;
    logic    step_fire;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign step_fire = in_valid_reg && advance;

    // Capture the incoming word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_tick_reg <= '{mode:       s_tuser[1:0],
                             dev_addr:   s_tdata[2:0],
                             reg_index:  s_tdata[10:3],
                             write_data: s_tdata[26:11],
                             sda_sample: s_tdata[27]};
        end
    end

    i2cmrt_step u_step (
        .cur  (ctrl_reg),
        .tick (in_tick_reg),
        .nxt  (ctrl_next),
        .res  (step_res)
    );

    // Commit one sequencer step per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '{phase: PH_IDLE, scl: 1'b1, sda: 1'b1, default: '0};
        end else if (step_fire) begin
            ctrl_reg <= ctrl_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_res_reg};

    // A finished transfer leaves the sequencer idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
        else $error("done reported while still busy");

    // ok is only raised together with done
    a_ok_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4]) |-> m_tdata[3])
        else $error("ok without done");

    // Write transfers keep the read accumulator cleared
    a_write_accum: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_reg.phase != PH_IDLE && !ctrl_reg.is_read) |-> (ctrl_reg.read_accum == 16'd0))
        else $error("read data changed during a write");

    // A tick without a request keeps an idle sequencer idle
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && ctrl_reg.phase == PH_IDLE && in_tick_reg.mode != MODE_WRITE
         && in_tick_reg.mode != MODE_READ) |=> (ctrl_reg.phase == PH_IDLE))
        else $error("sequencer left idle without a request");

endmodule

// ===== test/i2c_master_register_transfer_tb.sv =====
// Self-checking testbench for i2c_master_register_transfer: pin-update ticks in,
// one SCL/SDA/status word out per tick, checked against a cycle-level predictor.
// Depends on i2cmrt_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module i2c_master_register_transfer_tb
    import i2cmrt_pkg::*;
();

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int RAND_ITEMS = 880;
    localparam int QUIET_TAIL = 150;

    typedef struct {
        tick_t   tk;
        bit      typed;
        result_t res;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;
    logic [InUserW-1:0]  s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;

    // Predicted bus sequencer state
    phase_t      bus_phase;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [2:0]  slot;
    logic        rd_xfer;
    logic [2:0]  addr_q;
    logic [7:0]  reg_q;
    logic [15:0] data_q;
    logic [15:0] rd_acc;
    logic        scl_q;
    logic        sda_q;

    result_t     pending_words[$];
    stim_row_t   stim_table[$];
    bit          quiet = 1'b0;
    int          error_count = 0;
    int          ticks_sent = 0;
    int          writes_done = 0;
    int          reads_done = 0;
    int          starts_aborted = 0;

    i2c_master_register_transfer u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Byte shifted out in the current slot
    function automatic logic [7:0] next_tx_byte();
        case (slot)
            BYTE_ADDR: return ADDR_PREFIX | {5'd0, addr_q} | DIR_WRITE;
            BYTE_REG:  return reg_q;
            default: begin
                if (rd_xfer) return ADDR_PREFIX | {5'd0, addr_q} | DIR_READ;
                return (slot == BYTE_DATA_L) ? data_q[7:0] : data_q[15:8];
            end
        endcase
    endfunction

    // Advance the predicted sequencer by one tick and form the result word
    task automatic step_bus(input tick_t tk, output result_t r);
        logic fin;
        logic good;
        fin = 1'b0;
        good = 1'b0;
        case (bus_phase)
            PH_IDLE: begin
                if (tk.mode == MODE_WRITE || tk.mode == MODE_READ) begin
                    rd_xfer = (tk.mode == MODE_READ);
                    addr_q = tk.dev_addr;
                    reg_q = tk.reg_index;
                    data_q = tk.write_data;
                    rd_acc = '0;
                    slot = '0;
                    bit_cnt = '0;
                    shreg = '0;
                    sda_q = 1'b1;
                    scl_q = 1'b1;
                    bus_phase = PH_ST1;
                end
            end
            PH_ST0: begin
                sda_q = 1'b1;
                scl_q = 1'b1;
                bus_phase = PH_ST1;
            end
            PH_ST1: begin
                sda_q = 1'b0;
                bus_phase = PH_ST2;
            end
            PH_ST2: begin
                // SDA still high after pulling it low: the bus is not ours
                if (tk.sda_sample) begin
                    fin = 1'b1;
                    bus_phase = PH_IDLE;
                    starts_aborted++;
                end else begin
                    sda_q = 1'b0;
                    shreg = next_tx_byte();
                    bit_cnt = '0;
                    bus_phase = PH_TXL;
                end
            end
            PH_TXL: begin
                scl_q = 1'b0;
                bus_phase = (bit_cnt >= BITS_BYTE) ? PH_AKR : PH_TXD;
            end
            PH_TXD: begin
                sda_q = shreg[7];
                shreg = {shreg[6:0], 1'b0};
                bus_phase = PH_TXH;
            end
            PH_TXH: begin
                scl_q = 1'b1;
                bit_cnt = bit_cnt + 4'd1;
                bus_phase = PH_TXL;
            end
            PH_AKR: begin
                sda_q = 1'b1;
                bus_phase = PH_AKH;
            end
            PH_AKH: begin
                scl_q = 1'b1;
                bus_phase = PH_AKE;
            end
            PH_AKE: begin
                scl_q = 1'b0;
                slot = slot + 3'd1;
                if (rd_xfer && slot == BYTE_DATA_L) begin
                    bus_phase = PH_ST0;
                end else if (rd_xfer && slot >= BYTE_RD_LO) begin
                    bus_phase = PH_RXR;
                end else if (!rd_xfer && slot >= BYTE_LAST) begin
                    bus_phase = PH_SPL;
                end else begin
                    shreg = next_tx_byte();
                    bit_cnt = '0;
                    bus_phase = PH_TXD;
                end
            end
            PH_RXR: begin
                sda_q = 1'b1;
                bit_cnt = '0;
                shreg = '0;
                bus_phase = PH_RXL;
            end
            PH_RXL: begin
                // The bit clocked on the previous high phase is on SDA now
                scl_q = 1'b0;
                if (bit_cnt != 4'd0) shreg = {shreg[6:0], tk.sda_sample};
                if (bit_cnt >= BITS_BYTE) begin
                    if (slot == BYTE_RD_LO) rd_acc[7:0] = shreg;
                    else rd_acc[15:8] = shreg;
                    bus_phase = PH_MKS;
                end else begin
                    bus_phase = PH_RXH;
                end
            end
            PH_RXH: begin
                scl_q = 1'b1;
                bit_cnt = bit_cnt + 4'd1;
                bus_phase = PH_RXL;
            end
            PH_MKS: begin
                // ACK the low byte, NACK the high one
                sda_q = (slot == BYTE_RD_LO) ? 1'b0 : 1'b1;
                bus_phase = PH_MKH;
            end
            PH_MKH: begin
                scl_q = 1'b1;
                bus_phase = PH_MKL;
            end
            PH_MKL: begin
                scl_q = 1'b0;
                slot = slot + 3'd1;
                bus_phase = (slot == BYTE_LAST) ? PH_RXR : PH_SPL;
            end
            PH_SPL: begin
                sda_q = 1'b0;
                bus_phase = PH_SPH;
            end
            PH_SPH: begin
                scl_q = 1'b1;
                bus_phase = PH_SPE;
            end
            PH_SPE: begin
                sda_q = 1'b1;
                fin = 1'b1;
                good = 1'b1;
                bus_phase = PH_IDLE;
                if (rd_xfer) reads_done++;
                else writes_done++;
            end
            default: bus_phase = PH_IDLE;
        endcase
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.busy_res = (bus_phase != PH_IDLE);
        r.done_res = fin;
        r.ok = good;
        r.read_data = rd_acc;
    endtask

    // Random tick, steered by the predicted phase so most transfers get through
    function automatic tick_t pick_tick();
        tick_t t;
        int unsigned roll;
        t.dev_addr = 3'($urandom_range(0, 7));
        t.reg_index = 8'($urandom_range(0, 255));
        t.write_data = 16'($urandom_range(0, 65535));
        roll = $urandom_range(0, 19);
        if (bus_phase == PH_IDLE) begin
            if (roll < 8) t.mode = MODE_WRITE;
            else if (roll < 16) t.mode = MODE_READ;
            else if (roll < 19) t.mode = MODE_TICK;
            else t.mode = MODE_SPARE;
        end else begin
            t.mode = (roll == 0) ? 2'($urandom_range(0, 3)) : MODE_TICK;
        end
        if (bus_phase == PH_ST2) t.sda_sample = ($urandom_range(0, 9) == 0);
        else t.sda_sample = 1'($urandom_range(0, 1));
        return t;
    endfunction

    function automatic void add_row(input logic [1:0] mode, input logic [2:0] addr,
                                    input logic [7:0] rix, input logic [15:0] wdat,
                                    input logic samp, input bit typed, input logic scl,
                                    input logic sda, input logic busy, input logic fin,
                                    input logic good);
        stim_row_t row;
        row.tk = '{mode: mode, dev_addr: addr, reg_index: rix, write_data: wdat,
                   sda_sample: samp};
        row.typed = typed;
        row.res = '{read_data: 16'd0, ok: good, done_res: fin, busy_res: busy,
                    sda_level: sda, scl_level: scl};
        stim_table.push_back(row);
    endfunction

    // Present one word, hold it until taken, then record what it must produce
    task automatic send_word(input tick_t tk, input bit typed, input result_t typed_res);
        result_t pred;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= tk.mode;
        s_tdata <= {4'd0, tk.sda_sample, tk.write_data, tk.reg_index, tk.dev_addr};
        do @(posedge aclk); while (!s_tready);
        step_bus(tk, pred);
        pending_words.push_back(typed ? typed_res : pred);
        ticks_sent++;
    endtask

    task automatic idle_gap(input int unsigned cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each result word with the oldest expectation
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[20:0]);
            if (pending_words.size() == 0) begin
                $error("result word with nothing expected: %h", m_tdata);
                error_count++;
            end else begin
                want = pending_words.pop_front();
                check_field("scl_level", want.scl_level, got.scl_level);
                check_field("sda_level", want.sda_level, got.sda_level);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("done_res", want.done_res, got.done_res);
                check_field("ok", want.ok, got.ok);
                check_field("read_data", want.read_data, got.read_data);
            end
        end
    end

    // Result side: stall in random bursts except in quiet stretches
    initial begin
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else if (!quiet && aresetn && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        stim_row_t row;
        int n;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = MODE_TICK;
        aresetn = 1'b0;
        bus_phase = PH_IDLE;
        bit_cnt = '0;
        shreg = '0;
        slot = '0;
        rd_xfer = 1'b0;
        addr_q = '0;
        reg_q = '0;
        data_q = '0;
        rd_acc = '0;
        scl_q = 1'b1;
        sda_q = 1'b1;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: idle ticks, spare mode, request while busy, START aborts, a start
        //        mode        addr  reg     data        sda   chk   scl   sda   bsy   dn    ok
        add_row(MODE_TICK,  3'd0, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row(MODE_SPARE, 3'd7, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        add_row(MODE_WRITE, 3'd7, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        add_row(MODE_READ,  3'd0, 8'h00, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        add_row(MODE_TICK,  3'd5, 8'hA5, 16'h5A5A, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
        add_row(MODE_TICK,  3'd2, 8'h3C, 16'hC3C3, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(MODE_READ,  3'd0, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        add_row(MODE_TICK,  3'd0, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        add_row(MODE_TICK,  3'd0, 8'h00, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0);
        add_row(MODE_WRITE, 3'd0, 8'h00, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        add_row(MODE_TICK,  3'd7, 8'hFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        add_row(MODE_TICK,  3'd7, 8'hFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(MODE_WRITE, 3'd7, 8'hFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(MODE_READ,  3'd0, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(MODE_SPARE, 3'd7, 8'hFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(MODE_TICK,  3'd0, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(MODE_TICK,  3'd0, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_row(MODE_TICK,  3'd0, 8'h00, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);

        foreach (stim_table[i]) begin
            row = stim_table[i];
            if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 18));
            send_word(row.tk, row.typed, row.res);
        end

        // Random: mostly complete transfers with random payload and read-back bits
        for (n = 0; n < RAND_ITEMS; n++) begin
            quiet = (n >= RAND_ITEMS - QUIET_TAIL) || ((n / 128) % 3 == 1);
            if (!quiet && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 18));
            send_word(pick_tick(), 1'b0, '0);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain the pipeline, then leave room for any stray word
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);

        $display("Sent %0d ticks: %0d writes and %0d reads ran to STOP, %0d STARTs aborted",
                 ticks_sent, writes_done, reads_done, starts_aborted);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
